>>> src/fde_pkg.sv
package fde_pkg;

   localparam int DefDelayDepth = 1024;
   localparam int DefSampleBits = 24;
   localparam int DefSineTableBits = 10;
   localparam int QueueDepth = 4;

   // sine ROM entries are Q1.15, -32768..32768
   localparam int SineBits = 17;
   // delay product: offset (Q9.8) times 1+s (Q1.15)
   localparam int OffsetBits = 17;
   localparam int ProdBits = OffsetBits + SineBits;
   localparam int ProdShift = 23;
   localparam int CeilBits = ProdBits + 1 - ProdShift;

   localparam longint C1 = 421657428;
   localparam longint C3 = -173399667;
   localparam longint C5 = 21392326;
   localparam longint C7 = -1256749;
   localparam longint C9 = 43068;

   typedef enum logic [1:0] {
      RegEnable      = 2'd0,
      RegPhaseStep   = 2'd1,
      RegLfoPeriod   = 2'd2,
      RegDelayOffset = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic        effect_enable;
      logic [23:0] phase_step;
      logic [23:0] lfo_period;
      logic [16:0] delay_offset;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      effect_enable: 1'b1,
      phase_step:    24'd80531,
      lfo_period:    24'd53333,
      delay_offset:  17'd61440
   };

   // full-wave sine, quadrant folded odd polynomial, Q28 coefficients
   function automatic logic signed [SineBits-1:0] sine_entry(int unsigned addr,
                                                            int unsigned tbits);
      int unsigned qbits;
      int unsigned quarter;
      int unsigned quad;
      int unsigned r;
      int unsigned ang;
      longint      t;
      longint      t2;
      longint      acc;
      longint      y;
      qbits   = tbits - 2;
      quarter = 1 << qbits;
      quad    = (addr >> qbits) & 3;
      r       = addr & (quarter - 1);
      ang     = ((quad & 1) != 0) ? (quarter - r) : r;
      t       = longint'(ang) << (16 - qbits);
      t2      = (t * t) / 65536;
      acc     = C9;
      acc     = C7 + (acc * t2) / 65536;
      acc     = C5 + (acc * t2) / 65536;
      acc     = C3 + (acc * t2) / 65536;
      acc     = C1 + (acc * t2) / 65536;
      y       = (acc * t) / 65536;
      if (y < 0) y = 0;
      y = (y + 4096) / 8192;
      if (y > 32768) y = 32768;
      if ((quad & 2) != 0) y = -y;
      return SineBits'(y);
   endfunction

endpackage

>>> src/flanger_delay_effect.sv
// Flanger with a sine LFO. Each input beat gives one output beat, in order:
// the sample plus the sample ceil(delay_offset*(1+sin)) places back in a
// DELAY_DEPTH-entry delay line, saturated; with effect_enable low the sample
// passes through and line and LFO hold. Sustained rate is one beat per clock
// while the output is not stalled; each beat's LFO phase goes through the sine ROM,
// the delay multiplier and the registered delay-line RAM read. A four-beat queue
// between the front (LFO, write pointer) and the back pipeline absorbs output
// stall. After reset, req_stall stays high while the delay line is cleared;
// registers may be written during that time.
module flanger_delay_effect #(
   parameter int DelayDepth    = fde_pkg::DefDelayDepth,
   parameter int SampleBits    = fde_pkg::DefSampleBits,
   parameter int SineTableBits = fde_pkg::DefSineTableBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SampleBits-1:0] req_sample_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SampleBits-1:0] rsp_sample_out,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import fde_pkg::*;

   localparam int AddrW = $clog2(DelayDepth);
   localparam int ItemW = SampleBits + 1 + SineTableBits + AddrW;

   cfg_type       cfg_ff;
   reg_index_type reg_sel;
   logic          csr_wr;

   logic             push;
   logic [ItemW-1:0] push_item;
   logic             q_full;
   logic             q_empty;
   logic             pop;
   logic [ItemW-1:0] q_item;
   logic             clr_busy;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else if (csr_wr) begin
         unique case (reg_sel)
            RegEnable:      cfg_ff.effect_enable <= csr_pwdata[0];
            RegPhaseStep:   cfg_ff.phase_step    <= csr_pwdata[23:0];
            RegLfoPeriod:   cfg_ff.lfo_period    <= csr_pwdata[23:0];
            RegDelayOffset: cfg_ff.delay_offset  <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         RegEnable:      csr_prdata = 32'(cfg_ff.effect_enable);
         RegPhaseStep:   csr_prdata = 32'(cfg_ff.phase_step);
         RegLfoPeriod:   csr_prdata = 32'(cfg_ff.lfo_period);
         RegDelayOffset: csr_prdata = 32'(cfg_ff.delay_offset);
         default:        csr_prdata = '0;
      endcase
   end

   fde_front #(
      .DelayDepth    (DelayDepth),
      .SampleBits    (SampleBits),
      .SineTableBits (SineTableBits)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .q_full        (q_full),
      .clr_busy      (clr_busy),
      .push          (push),
      .push_item     (push_item)
   );

   fde_fifo #(
      .Width (ItemW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .pop_item  (q_item)
   );

   fde_back #(
      .DelayDepth    (DelayDepth),
      .SampleBits    (SampleBits),
      .SineTableBits (SineTableBits)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_item         (q_item),
      .pop            (pop),
      .clr_busy       (clr_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

>>> src/fde_fifo.sv
module fde_fifo #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_item,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [Width-1:0] pop_item
);
   import fde_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = PtrW + 1;

   logic [Width-1:0] slot_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [PtrW-1:0]  wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_in;
   logic [CntW-1:0]  cnt_in;

   assign full     = (cnt_ff == CntW'(QueueDepth));
   assign empty    = (cnt_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop) rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/fde_front.sv
module fde_front #(
   parameter int DelayDepth    = fde_pkg::DefDelayDepth,
   parameter int SampleBits    = fde_pkg::DefSampleBits,
   parameter int SineTableBits = fde_pkg::DefSineTableBits,
   localparam int AddrW        = $clog2(DelayDepth),
   localparam int ItemW        = SampleBits + 1 + SineTableBits + AddrW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fde_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SampleBits-1:0] req_sample_in,
   input  logic                  q_full,
   input  logic                  clr_busy,
   output logic                  push,
   output logic [ItemW-1:0]      push_item
);
   import fde_pkg::*;

   logic [AddrW-1:0] widx_ff;
   logic [31:0]      phase_ff;
   logic [23:0]      count_ff;
   logic [AddrW-1:0] widx_in;
   logic [31:0]      phase_in;
   logic [23:0]      count_in;
   logic [31:0]      phase_adv;
   logic [23:0]      count_adv;
   logic             accept;

   assign req_stall = q_full || clr_busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      phase_adv = phase_ff + 32'(cfg.phase_step);
      count_adv = count_ff + 24'd1;
      if (count_adv >= cfg.lfo_period) begin
         phase_in = '0;
         count_in = '0;
      end else begin
         phase_in = phase_adv;
         count_in = count_adv;
      end
      widx_in = (widx_ff == AddrW'(DelayDepth - 1)) ? '0 : widx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff  <= '0;
         phase_ff <= '0;
         count_ff <= '0;
      end else if (accept && cfg.effect_enable) begin
         widx_ff  <= widx_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   assign push      = accept;
   assign push_item = {req_sample_in, cfg.effect_enable,
                       phase_in[31 -: SineTableBits], widx_ff};

endmodule

>>> src/fde_back.sv
module fde_back #(
   parameter int DelayDepth    = fde_pkg::DefDelayDepth,
   parameter int SampleBits    = fde_pkg::DefSampleBits,
   parameter int SineTableBits = fde_pkg::DefSineTableBits,
   localparam int AddrW        = $clog2(DelayDepth),
   localparam int ItemW        = SampleBits + 1 + SineTableBits + AddrW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fde_pkg::cfg_type      cfg,
   input  logic                  q_empty,
   input  logic [ItemW-1:0]      q_item,
   output logic                  pop,
   output logic                  clr_busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SampleBits-1:0] rsp_sample_out
);
   import fde_pkg::*;

   localparam int TableSize = 1 << SineTableBits;
   localparam int CeilBias  = (1 << ProdShift) - 1;

   logic signed [SineBits-1:0] sine_rom [TableSize];

   for (genvar k = 0; k < TableSize; k++) begin : g_rom
      assign sine_rom[k] = sine_entry(k, SineTableBits);
   end

   logic [SampleBits-1:0]    q_x;
   logic                     q_en;
   logic [SineTableBits-1:0] q_addr;
   logic [AddrW-1:0]         q_newest;
   logic                     adv;

   assign q_x      = q_item[ItemW-1 -: SampleBits];
   assign q_en     = q_item[AddrW + SineTableBits];
   assign q_addr   = q_item[AddrW +: SineTableBits];
   assign q_newest = q_item[AddrW-1:0];

   assign adv = !rsp_valid || !rsp_stall;
   assign pop = adv && !q_empty;

   // stage 1: sine lookup
   logic                       v1_ff;
   logic [SampleBits-1:0]      x1_ff;
   logic                       en1_ff;
   logic [AddrW-1:0]           nw1_ff;
   logic signed [SineBits-1:0] s1_ff;

   // stage 2: delay product
   logic                  v2_ff;
   logic [SampleBits-1:0] x2_ff;
   logic                  en2_ff;
   logic [AddrW-1:0]      nw2_ff;
   logic [ProdBits-1:0]   p2_ff;
   logic [SineBits-1:0]   gain1;
   logic [ProdBits-1:0]   p2_in;

   // stage 3: line write and read
   logic                  v3_ff;
   logic [SampleBits-1:0] x3_ff;
   logic                  en3_ff;
   logic                  byp3_ff;
   logic [SampleBits-1:0] rd_data_ff;
   logic [ProdBits:0]     ceil_sum;
   logic [CeilBits-1:0]   ceil_n;
   logic [AddrW-1:0]      n_dly;
   logic [AddrW-1:0]      rd_addr;

   // stage 4: sum and saturate
   logic                  rsp_valid_ff;
   logic [SampleBits-1:0] rsp_sample_ff;
   logic [SampleBits-1:0] dly;
   logic [SampleBits:0]   sum;
   logic [SampleBits-1:0] sat;
   logic [SampleBits-1:0] rsp_sample_in;

   // clearing pass
   logic             clr_busy_ff;
   logic [AddrW-1:0] clr_addr_ff;

   logic [SampleBits-1:0] dline_mem [DelayDepth];

   always_comb begin
      gain1 = SineBits'(s1_ff) + SineBits'(32768);
      p2_in = ProdBits'(cfg.delay_offset) * ProdBits'(gain1);
   end

   always_comb begin
      ceil_sum = {1'b0, p2_ff} + (ProdBits + 1)'(CeilBias);
      ceil_n   = ceil_sum[ProdBits -: CeilBits];
      if (32'(ceil_n) > 32'(DelayDepth - 1)) begin
         n_dly = AddrW'(DelayDepth - 1);
      end else begin
         n_dly = AddrW'(ceil_n);
      end
      if (nw2_ff < n_dly) begin
         rd_addr = nw2_ff - n_dly + AddrW'(DelayDepth);
      end else begin
         rd_addr = nw2_ff - n_dly;
      end
   end

   always_comb begin
      dly = byp3_ff ? x3_ff : rd_data_ff;
      sum = {x3_ff[SampleBits-1], x3_ff} + {dly[SampleBits-1], dly};
      if (sum[SampleBits] != sum[SampleBits-1]) begin
         sat = sum[SampleBits] ? {1'b1, {(SampleBits - 1){1'b0}}}
                               : {1'b0, {(SampleBits - 1){1'b1}}};
      end else begin
         sat = sum[SampleBits-1:0];
      end
      rsp_sample_in = en3_ff ? sat : x3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= pop;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff         <= q_x;
         en1_ff        <= q_en;
         nw1_ff        <= q_newest;
         s1_ff         <= sine_rom[q_addr];
         x2_ff         <= x1_ff;
         en2_ff        <= en1_ff;
         nw2_ff        <= nw1_ff;
         p2_ff         <= p2_in;
         x3_ff         <= x2_ff;
         en3_ff        <= en2_ff;
         byp3_ff       <= (n_dly == '0);
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AddrW'(DelayDepth - 1)) clr_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dline_mem[clr_addr_ff] <= '0;
      end else if (adv && v2_ff && en2_ff) begin
         dline_mem[nw2_ff] <= x2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_data_ff <= dline_mem[rd_addr];
      end
   end

   assign clr_busy       = clr_busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

>>> tb/flanger_delay_effect_tb.sv
module flanger_delay_effect_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fde_pkg::*;

   localparam int SampleBits = DefSampleBits;
   localparam int LineDepth  = DefDelayDepth;
   localparam int TableBits  = DefSineTableBits;
   localparam int IdxBits    = $clog2(LineDepth);
   localparam longint SampleMax = (longint'(1) << (SampleBits - 1)) - 1;
   localparam longint SampleMin = -SampleMax - 1;
   localparam logic [SampleBits-1:0] TopSample    = {1'b0, {(SampleBits - 1){1'b1}}};
   localparam logic [SampleBits-1:0] BottomSample = {1'b1, {(SampleBits - 1){1'b0}}};

   // sine polynomial coefficients, Q28
   localparam longint K1 = 421657428;
   localparam longint K3 = -173399667;
   localparam longint K5 = 21392326;
   localparam longint K7 = -1256749;
   localparam longint K9 = 43068;

   localparam int IdleLimit   = 5000;
   localparam int HoldCycles  = 64;
   localparam int PhaseCount  = 12;
   localparam int PhaseItems  = 150;
   localparam int PlanLen     = 33;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SampleBits-1:0] req_sample_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SampleBits-1:0] rsp_sample_out;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [3:0]            csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   flanger_delay_effect dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // flanger state mirror
   cfg_type                     flange_cfg;
   logic signed [SampleBits-1:0] line_mem [LineDepth];
   logic [IdxBits-1:0]          line_wr;
   logic [31:0]                 lfo_acc;
   logic [23:0]                 lfo_cnt;

   logic [SampleBits-1:0] expected_out_q [$];
   int                    error_count = 0;
   int                    idle_cycles = 0;
   bit                    calm = 0;
   bit                    hold_pending = 0;

   typedef struct {
      bit                    is_cfg;
      reg_index_type         idx;
      logic [31:0]           value;
      bit                    typed;
      logic [SampleBits-1:0] out;
   } plan_row_type;

   plan_row_type plan [PlanLen] = '{
      '{1'b0, RegEnable,      32'h000000, 1'b1, 24'h000000},
      '{1'b0, RegEnable,      32'h7FFFFF, 1'b1, 24'h7FFFFF},
      '{1'b0, RegEnable,      32'h800000, 1'b1, 24'h800000},
      '{1'b0, RegEnable,      32'h000001, 1'b1, 24'h000001},
      '{1'b0, RegEnable,      32'hFFFFFF, 1'b1, 24'hFFFFFF},
      '{1'b1, RegEnable,      32'd0,      1'b0, 24'h0},
      '{1'b0, RegEnable,      32'd123456, 1'b1, 24'd123456},
      '{1'b0, RegEnable,      32'h800000, 1'b1, 24'h800000},
      '{1'b1, RegEnable,      32'd1,      1'b0, 24'h0},
      '{1'b1, RegDelayOffset, 32'd0,      1'b0, 24'h0},
      '{1'b0, RegEnable,      32'h7FFFFF, 1'b1, 24'h7FFFFF},
      '{1'b0, RegEnable,      32'h800000, 1'b1, 24'h800000},
      '{1'b0, RegEnable,      32'h000003, 1'b1, 24'h000006},
      '{1'b0, RegEnable,      32'hFFFFFF, 1'b1, 24'hFFFFFE},
      '{1'b0, RegEnable,      32'h400000, 1'b1, 24'h7FFFFF},
      '{1'b1, RegLfoPeriod,   32'd0,      1'b0, 24'h0},
      '{1'b1, RegDelayOffset, 32'd1280,   1'b0, 24'h0},
      '{1'b0, RegEnable,      32'd1000,   1'b0, 24'h0},
      '{1'b0, RegEnable,      32'hFFFC18, 1'b0, 24'h0},
      '{1'b0, RegEnable,      32'h7FFFFF, 1'b0, 24'h0},
      '{1'b0, RegEnable,      32'h800000, 1'b0, 24'h0},
      '{1'b0, RegEnable,      32'd77,     1'b0, 24'h0},
      '{1'b1, RegPhaseStep,   32'hFFFFFF, 1'b0, 24'h0},
      '{1'b1, RegLfoPeriod,   32'hFFFFFF, 1'b0, 24'h0},
      '{1'b1, RegDelayOffset, 32'h1FFFF,  1'b0, 24'h0},
      '{1'b0, RegEnable,      32'h555555, 1'b0, 24'h0},
      '{1'b0, RegEnable,      32'hAAAAAA, 1'b0, 24'h0},
      '{1'b0, RegEnable,      32'h7FFFFF, 1'b0, 24'h0},
      '{1'b0, RegEnable,      32'h800000, 1'b0, 24'h0},
      '{1'b0, RegEnable,      32'd123,    1'b0, 24'h0},
      '{1'b1, RegPhaseStep,   32'd0,      1'b0, 24'h0},
      '{1'b0, RegEnable,      32'h400000, 1'b0, 24'h0},
      '{1'b0, RegEnable,      32'hC00000, 1'b0, 24'h0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint lfo_sine(logic [TableBits-1:0] addr);
      longint     quarter;
      longint     r;
      longint     ang;
      longint     t;
      longint     t2;
      longint     acc;
      longint     y;
      logic [1:0] quad;
      quarter = longint'(1) << (TableBits - 2);
      quad    = addr[TableBits-1 -: 2];
      r       = longint'(addr) & (quarter - 1);
      ang     = quad[0] ? quarter - r : r;
      t       = ang << (18 - TableBits);
      t2      = (t * t) / 65536;
      acc     = K9;
      acc     = K7 + (acc * t2) / 65536;
      acc     = K5 + (acc * t2) / 65536;
      acc     = K3 + (acc * t2) / 65536;
      acc     = K1 + (acc * t2) / 65536;
      y       = (acc * t) / 65536;
      if (y < 0) y = 0;
      y = (y + 4096) / 8192;
      if (y > 32768) y = 32768;
      return quad[1] ? -y : y;
   endfunction

   function automatic void flange_reset();
      flange_cfg = CfgReset;
      foreach (line_mem[i]) line_mem[i] = '0;
      line_wr = '0;
      lfo_acc = '0;
      lfo_cnt = '0;
   endfunction

   // write, advance LFO, then read back from the advanced phase
   function automatic logic [SampleBits-1:0] flange_sample(logic [SampleBits-1:0] raw);
      longint             x;
      longint             s;
      longint             p;
      longint             n;
      longint             sum;
      logic [IdxBits-1:0] newest;
      logic [IdxBits-1:0] rd;
      x = longint'($signed(raw));
      if (!flange_cfg.effect_enable) return raw;
      newest = line_wr;
      line_mem[newest] = raw;
      line_wr = newest + 1'b1;
      lfo_acc = lfo_acc + 32'(flange_cfg.phase_step);
      lfo_cnt = lfo_cnt + 1'b1;
      if (lfo_cnt >= flange_cfg.lfo_period) begin
         lfo_cnt = '0;
         lfo_acc = '0;
      end
      s = lfo_sine(lfo_acc[31 -: TableBits]);
      p = longint'(flange_cfg.delay_offset) * (32768 + s);
      n = (p + (longint'(1) << 23) - 1) >>> 23;
      if (n > LineDepth - 1) n = LineDepth - 1;
      rd = newest - IdxBits'(n);
      sum = x + longint'(line_mem[rd]);
      if (sum > SampleMax) sum = SampleMax;
      if (sum < SampleMin) sum = SampleMin;
      return SampleBits'(sum);
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [SampleBits-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return TopSample;
         1: return BottomSample;
         2: return SampleBits'($urandom_range(0, 31)) - SampleBits'(16);
         default: return SampleBits'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [SampleBits-1:0] got,
                                  logic [SampleBits-1:0] want);
      if (error_count < 30)
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
                  $signed(want), $realtime);
      error_count++;
   endtask

   task automatic send_sample(logic [SampleBits-1:0] x, bit typed,
                              logic [SampleBits-1:0] typed_out);
      int                    gap;
      logic [SampleBits-1:0] want;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall);
      want = flange_sample(x);
      expected_out_q.push_back(typed ? typed_out : want);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         RegEnable:      flange_cfg.effect_enable = value[0];
         RegPhaseStep:   flange_cfg.phase_step    = value[23:0];
         RegLfoPeriod:   flange_cfg.lfo_period    = value[23:0];
         RegDelayOffset: flange_cfg.delay_offset  = value[16:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stall, plus one long hold-off on request
   initial begin : rsp_side
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            n = HoldCycles;
         end else begin
            n = pick_gap();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if (!calm) repeat ($urandom_range(0, 3)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      logic [SampleBits-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_sample_out, '0);
         end else begin
            want = expected_out_q.pop_front();
            if (rsp_sample_out !== want) report_mismatch("sample_out", rsp_sample_out, want);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] step;
      logic [31:0] period;
      logic [31:0] offset;
      logic [31:0] enable;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_in <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      flange_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            drain_results();
            csr_write(plan[i].idx, plan[i].value);
         end else begin
            send_sample(plan[i].value[SampleBits-1:0], plan[i].typed, plan[i].out);
         end
      end

      for (int ph = 0; ph < PhaseCount; ph++) begin
         if (ph == 0) begin
            enable = 1;
            step   = 0;
            period = 1;
            offset = 0;
         end else if (ph == 1) begin
            enable = 1;
            step   = 32'hFFFFFF;
            period = 32'hFFFFFF;
            offset = 32'h1FFFF;
         end else begin
            enable = 32'($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 3))
               0: step = $urandom_range(0, 255);
               default: step = $urandom & 32'hFFFFFF;
            endcase
            case ($urandom_range(0, 3))
               0: period = $urandom_range(0, 40);
               1: period = $urandom & 32'hFFFFFF;
               2: period = $urandom_range(100, 3000);
               default: period = 32'hFFFFFF;
            endcase
            case ($urandom_range(0, 4))
               0: offset = 130816;
               1: offset = 32'h1FFFF;
               default: offset = $urandom_range(0, 131071);
            endcase
         end
         drain_results();
         csr_write(RegEnable, enable);
         csr_write(RegPhaseStep, step);
         csr_write(RegLfoPeriod, period);
         csr_write(RegDelayOffset, offset);
         calm = (ph % 4 == 2);
         if (ph == 3) hold_pending = 1'b1;
         repeat (PhaseItems) send_sample(pick_sample(), 1'b0, '0);
      end
      calm = 1'b0;

      drain_results();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
src/fde_pkg.sv
src/fde_fifo.sv
src/fde_front.sv
src/fde_back.sv
src/flanger_delay_effect.sv
tb/flanger_delay_effect_tb.sv
